/* src/circle_circle_intersection_assert.svh */
// Assertion macros shared by the circle intersection RTL.
`ifndef CIRCLE_CIRCLE_INTERSECTION_ASSERT_SVH
`define CIRCLE_CIRCLE_INTERSECTION_ASSERT_SVH

// Same-cycle implication.
`define CCI_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define CCI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/cci_pkg.sv */
package cci_pkg;

   localparam int VAL_W           = 64;
   localparam int DEF_COORD_WIDTH = 32;
   localparam int DEF_FRAC_BITS   = 16;
   localparam int CSR_W           = 32;
   localparam int STATUS_W        = 2;

   typedef logic [VAL_W-1:0] val_type;

   localparam val_type VAL_MAX = '1;
   localparam val_type LIN_CAP = 64'h2000_0000_0000_0000;
   localparam val_type K2_CAP  = 64'h4000_0000_0000_0000;

   localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_CONCENTRIC = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_APART      = 2'd2;

endpackage

/* src/cci_mul.sv */
// Pipelined capped fixed-point multiply: min(floor(a*b / 2^FRAC_BITS), cap).
// Three stages: partial products, sum, shift and cap.
module cci_mul
   import cci_pkg::*;
#(
   parameter int LANES     = 1,
   parameter int FRAC_BITS = DEF_FRAC_BITS,
   parameter int SIDE_W    = 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_valid,
   input  val_type [LANES-1:0]     a,
   input  val_type [LANES-1:0]     b,
   input  val_type [LANES-1:0]     cap,
   input  logic [SIDE_W-1:0]       in_side,
   output logic                    out_valid,
   output val_type [LANES-1:0]     prod,
   output logic [SIDE_W-1:0]       out_side
);

   localparam int HALF   = VAL_W / 2;
   localparam int PROD_W = 2 * VAL_W;

   logic                  v1_ff, v2_ff, v3_ff;
   logic [SIDE_W-1:0]     side1_ff, side2_ff, side3_ff;
   val_type [LANES-1:0]   cap1_ff, cap2_ff;
   val_type [LANES-1:0]   p00_in, p01_in, p10_in, p11_in;
   val_type [LANES-1:0]   p00_ff, p01_ff, p10_ff, p11_ff;
   logic [PROD_W-1:0]     sum_in [LANES];
   logic [PROD_W-1:0]     sum_ff [LANES];
   val_type [LANES-1:0]   mid;
   val_type [LANES-1:0]   res_in, res_ff;

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         p00_in[l] = VAL_W'(a[l][HALF-1:0]) * VAL_W'(b[l][HALF-1:0]);
         p01_in[l] = VAL_W'(a[l][HALF-1:0]) * VAL_W'(b[l][VAL_W-1:HALF]);
         p10_in[l] = VAL_W'(a[l][VAL_W-1:HALF]) * VAL_W'(b[l][HALF-1:0]);
         p11_in[l] = VAL_W'(a[l][VAL_W-1:HALF]) * VAL_W'(b[l][VAL_W-1:HALF]);
         sum_in[l] = PROD_W'(p00_ff[l]) + (PROD_W'(p01_ff[l]) << HALF)
                   + (PROD_W'(p10_ff[l]) << HALF) + (PROD_W'(p11_ff[l]) << VAL_W);
         mid[l]    = sum_ff[l][VAL_W+FRAC_BITS-1:FRAC_BITS];
         res_in[l] = ((|sum_ff[l][PROD_W-1:VAL_W+FRAC_BITS]) || (mid[l] > cap2_ff[l]))
                   ? cap2_ff[l] : mid[l];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p00_ff   <= p00_in;
         p01_ff   <= p01_in;
         p10_ff   <= p10_in;
         p11_ff   <= p11_in;
         cap1_ff  <= cap;
         side1_ff <= in_side;
         sum_ff   <= sum_in;
         cap2_ff  <= cap1_ff;
         side2_ff <= side1_ff;
         res_ff   <= res_in;
         side3_ff <= side2_ff;
      end
   end

   assign out_valid = v3_ff;
   assign prod      = res_ff;
   assign out_side  = side3_ff;

endmodule

/* src/cci_div.sv */
// Pipelined restoring divider, one quotient bit per stage, several
// numerators over one shared divisor.
module cci_div
   import cci_pkg::*;
#(
   parameter int LANES  = 2,
   parameter int SIDE_W = 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  val_type [LANES-1:0] num,
   input  val_type             den,
   input  logic [SIDE_W-1:0]   in_side,
   output logic                out_valid,
   output val_type [LANES-1:0] quo,
   output logic [SIDE_W-1:0]   out_side
);

   logic                v_ff    [VAL_W];
   val_type             den_ff  [VAL_W];
   logic [SIDE_W-1:0]   side_ff [VAL_W];
   val_type [LANES-1:0] num_ff  [VAL_W];
   val_type [LANES-1:0] quo_ff  [VAL_W];
   val_type [LANES-1:0] rem_ff  [VAL_W];

   for (genvar s = 0; s < VAL_W; s++) begin : g_stage
      logic                v_prev;
      val_type             den_prev;
      logic [SIDE_W-1:0]   side_prev;
      val_type [LANES-1:0] num_prev, quo_prev, rem_prev;
      val_type [LANES-1:0] num_in, quo_in, rem_in;
      logic [VAL_W:0]      trial [LANES];
      logic [LANES-1:0]    ge;

      if (s == 0) begin : g_first
         assign v_prev    = in_valid;
         assign den_prev  = den;
         assign side_prev = in_side;
         assign num_prev  = num;
         assign quo_prev  = '0;
         assign rem_prev  = '0;
      end else begin : g_next
         assign v_prev    = v_ff[s-1];
         assign den_prev  = den_ff[s-1];
         assign side_prev = side_ff[s-1];
         assign num_prev  = num_ff[s-1];
         assign quo_prev  = quo_ff[s-1];
         assign rem_prev  = rem_ff[s-1];
      end

      always_comb begin
         for (int l = 0; l < LANES; l++) begin
            trial[l]  = {rem_prev[l], num_prev[l][VAL_W-1]};
            ge[l]     = trial[l] >= {1'b0, den_prev};
            rem_in[l] = ge[l] ? VAL_W'(trial[l] - {1'b0, den_prev}) : VAL_W'(trial[l]);
            quo_in[l] = {quo_prev[l][VAL_W-2:0], ge[l]};
            num_in[l] = num_prev[l] << 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else if (en) begin
            v_ff[s] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            den_ff[s]  <= den_prev;
            side_ff[s] <= side_prev;
            num_ff[s]  <= num_in;
            quo_ff[s]  <= quo_in;
            rem_ff[s]  <= rem_in;
         end
      end
   end

   assign out_valid = v_ff[VAL_W-1];
   assign quo       = quo_ff[VAL_W-1];
   assign out_side  = side_ff[VAL_W-1];

endmodule

/* src/circle_circle_intersection.sv */
// Channel | Dir | Contents
// --------+-----+------------------------------------------------------------
// req_*   | in  | one circle pair per transaction; tuser = distance_given
// rsp_*   | out | two intersection points per transaction; tuser = status
// csr_*   | in  | write-only min_center_dist_sq register
//
// Fully pipelined: one transaction may enter every cycle while the output queue is not full.
// The 64-stage divider and the square-root stages produce one result bit per stage.
// Reset is synchronous and clears valid bits and the register (to 1).
// A two-entry output queue absorbs backpressure; the pipeline holds only once
// both entries are full, so no transaction is lost or repeated.
module circle_circle_intersection
   import cci_pkg::*;
#(
   parameter int COORD_WIDTH = DEF_COORD_WIDTH,
   parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_tvalid,
   output logic                                      req_tready,
   // first_center_x, first_center_y, first_radius, second_center_x,
   // second_center_y, second_radius, given_distance (lowest first)
   input  logic [((7*COORD_WIDTH+4)/8)*8-1:0]        req_tdata,
   // distance_given
   input  logic [0:0]                                req_tuser,
   output logic                                      rsp_tvalid,
   input  logic                                      rsp_tready,
   // point_a_x, point_a_y, point_b_x, point_b_y (lowest first)
   output logic [((4*COORD_WIDTH+7)/8)*8-1:0]        rsp_tdata,
   // status
   output logic [STATUS_W-1:0]                       rsp_tuser,
   input  logic                                      csr_wr_en,
   input  logic [CSR_W-1:0]                          csr_wr_data
);

   localparam int RAD_W      = COORD_WIDTH - 1;
   localparam int DIF_W      = COORD_WIDTH + 1;
   localparam int RSP_DATA_W = ((4*COORD_WIDTH+7)/8)*8;
   localparam int X1_LSB     = 0;
   localparam int Y1_LSB     = COORD_WIDTH;
   localparam int R1_LSB     = 2*COORD_WIDTH;
   localparam int X2_LSB     = 3*COORD_WIDTH - 1;
   localparam int Y2_LSB     = 4*COORD_WIDTH - 1;
   localparam int R2_LSB     = 5*COORD_WIDTH - 1;
   localparam int G_LSB      = 6*COORD_WIDTH - 2;
   localparam int SQ_PAIRS   = (VAL_W + FRAC_BITS + 1) / 2;
   localparam int SQ_W       = 2*SQ_PAIRS;
   localparam int SQ_RW      = SQ_PAIRS + 2;
   localparam int SQ_TW      = SQ_PAIRS + 4;
   localparam val_type ONE_FIX = val_type'(1) << FRAC_BITS;
   localparam logic signed [VAL_W-1:0] SAT_HI =
      $signed({{(VAL_W-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}});
   localparam logic signed [VAL_W-1:0] SAT_LO = ~SAT_HI;

   typedef struct packed {
      logic [COORD_WIDTH-1:0] x1, y1, x2, y2;
      logic [RAD_W-1:0]       r1, r2, g;
      logic                   dg;
   } in_type;

   typedef struct packed {
      logic             dg, dxneg, dyneg;
      logic [DIF_W-1:0] dxmag, dymag, sumx, sumy;
   } geo_type;

   typedef struct packed {
      geo_type          geo;
      logic [RAD_W-1:0] r1, r2, g;
   } sub_type;

   typedef struct packed {
      val_type d2, diff, rsum;
      logic    k2neg;
      geo_type geo;
   } coef_type;

   typedef struct packed {
      logic    conc, k2neg;
      geo_type geo;
   } div_side_type;

   typedef struct packed {
      val_type      k2, t;
      div_side_type ds;
   } k2sq_side_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      val_type             k2;
      logic                k2neg;
      geo_type             geo;
   } root_side_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                k2neg;
      geo_type             geo;
   } lin_side_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      val_type             fx, fy, gx, gy;
   } term_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      val_type             sax, say, sbx, sby;
   } sum_type;

   typedef struct packed {
      logic [STATUS_W-1:0]    status;
      logic [COORD_WIDTH-1:0] by, bx, ay, ax;
   } out_type;

   function automatic val_type add_sat(input val_type x, input val_type y);
      logic [VAL_W:0] s;
      s = {1'b0, x} + {1'b0, y};
      return s[VAL_W] ? VAL_MAX : s[VAL_W-1:0];
   endfunction

   function automatic val_type shl_cap(input val_type v, input int n, input val_type cap);
      val_type shifted;
      logic    lost;
      shifted = v << n;
      lost    = (v >> (VAL_W - n)) != '0;
      return (lost || shifted > cap) ? cap : shifted;
   endfunction

   function automatic val_type apply_sign(input val_type m, input logic neg);
      return neg ? (~m + val_type'(1)) : m;
   endfunction

   function automatic logic [COORD_WIDTH-1:0] half_sat(input val_type s);
      logic signed [VAL_W-1:0] h;
      h = $signed(s) >>> 1;
      if (h > SAT_HI) begin
         h = SAT_HI;
      end else if (h < SAT_LO) begin
         h = SAT_LO;
      end
      return h[COORD_WIDTH-1:0];
   endfunction

   logic               en;
   logic               out_v_ff, skid_v_ff;
   logic [CSR_W-1:0]   min_ff;

   // Register write; the user must change it only while the pipeline is empty, the block does not enforce this.
   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= CSR_W'(1);
      end else if (csr_wr_en) begin
         min_ff <= csr_wr_data;
      end
   end

   // ---------------- stage A: capture the transaction ----------------
   logic   a_v_ff;
   in_type a_in, a_ff;

   assign en         = !skid_v_ff;
   assign req_tready = en;

   always_comb begin
      a_in.x1 = req_tdata[X1_LSB +: COORD_WIDTH];
      a_in.y1 = req_tdata[Y1_LSB +: COORD_WIDTH];
      a_in.r1 = req_tdata[R1_LSB +: RAD_W];
      a_in.x2 = req_tdata[X2_LSB +: COORD_WIDTH];
      a_in.y2 = req_tdata[Y2_LSB +: COORD_WIDTH];
      a_in.r2 = req_tdata[R2_LSB +: RAD_W];
      a_in.g  = req_tdata[G_LSB +: RAD_W];
      a_in.dg = req_tuser[0];
   end

   // ---------------- stage B: center differences and sums ----------------
   logic                    b_v_ff;
   sub_type                 b_in, b_ff;
   logic signed [DIF_W-1:0] dx_s, dy_s;

   assign dx_s = $signed({a_ff.x2[COORD_WIDTH-1], a_ff.x2})
               - $signed({a_ff.x1[COORD_WIDTH-1], a_ff.x1});
   assign dy_s = $signed({a_ff.y2[COORD_WIDTH-1], a_ff.y2})
               - $signed({a_ff.y1[COORD_WIDTH-1], a_ff.y1});

   always_comb begin
      b_in.geo.dg    = a_ff.dg;
      b_in.geo.dxneg = dx_s[DIF_W-1];
      b_in.geo.dyneg = dy_s[DIF_W-1];
      b_in.geo.dxmag = dx_s[DIF_W-1] ? DIF_W'(-dx_s) : DIF_W'(dx_s);
      b_in.geo.dymag = dy_s[DIF_W-1] ? DIF_W'(-dy_s) : DIF_W'(dy_s);
      b_in.geo.sumx  = {a_ff.x1[COORD_WIDTH-1], a_ff.x1} + {a_ff.x2[COORD_WIDTH-1], a_ff.x2};
      b_in.geo.sumy  = {a_ff.y1[COORD_WIDTH-1], a_ff.y1} + {a_ff.y2[COORD_WIDTH-1], a_ff.y2};
      b_in.r1        = a_ff.r1;
      b_in.r2        = a_ff.r2;
      b_in.g         = a_ff.g;
   end

   // ---------------- squares: dx^2, dy^2, g^2, r1^2, r2^2 ----------------
   val_type [4:0]           m1_a, m1_cap, m1_p;
   logic                    m1_v;
   logic [$bits(geo_type)-1:0] m1_side;

   assign m1_a[0] = VAL_W'(b_ff.geo.dxmag);
   assign m1_a[1] = VAL_W'(b_ff.geo.dymag);
   assign m1_a[2] = VAL_W'(b_ff.g);
   assign m1_a[3] = VAL_W'(b_ff.r1);
   assign m1_a[4] = VAL_W'(b_ff.r2);
   assign m1_cap  = {5{VAL_MAX}};

   cci_mul #(
      .LANES     (5),
      .FRAC_BITS (FRAC_BITS),
      .SIDE_W    ($bits(geo_type))
   ) u_mul_sq (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (b_v_ff),
      .a         (m1_a),
      .b         (m1_a),
      .cap       (m1_cap),
      .in_side   (b_ff.geo),
      .out_valid (m1_v),
      .prod      (m1_p),
      .out_side  (m1_side)
   );

   // ---------------- stage C: D2, difference and sum of squared radii ----------------
   logic     c_v_ff;
   coef_type c_in, c_ff;

   always_comb begin
      c_in.geo   = geo_type'(m1_side);
      c_in.d2    = c_in.geo.dg ? m1_p[2] : add_sat(m1_p[0], m1_p[1]);
      c_in.k2neg = m1_p[3] < m1_p[4];
      c_in.diff  = c_in.k2neg ? (m1_p[4] - m1_p[3]) : (m1_p[3] - m1_p[4]);
      c_in.rsum  = add_sat(m1_p[3], m1_p[4]);
   end

   // ---------------- stage D: concentric test, scaled numerators ----------------
   logic         d_v_ff;
   div_side_type d_side_in, d_side_ff;
   val_type      d_k2num_in, d_k2num_ff, d_tnum_in, d_tnum_ff, d_d2_ff;

   always_comb begin
      d_side_in.conc  = (c_ff.d2 == '0) || (c_ff.d2 < VAL_W'(min_ff));
      d_side_in.k2neg = c_ff.k2neg;
      d_side_in.geo   = c_ff.geo;
      d_k2num_in      = shl_cap(c_ff.diff, FRAC_BITS, K2_CAP);
      d_tnum_in       = shl_cap(c_ff.rsum, FRAC_BITS + 1, VAL_MAX);
   end

   // ---------------- divide: k2 and t over D2 ----------------
   val_type [1:0]                   dv_num, dv_quo;
   logic                            dv_v;
   logic [$bits(div_side_type)-1:0] dv_side;

   assign dv_num[0] = d_k2num_ff;
   assign dv_num[1] = d_tnum_ff;

   cci_div #(
      .LANES     (2),
      .SIDE_W    ($bits(div_side_type))
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (d_v_ff),
      .num       (dv_num),
      .den       (d_d2_ff),
      .in_side   (d_side_ff),
      .out_valid (dv_v),
      .quo       (dv_quo),
      .out_side  (dv_side)
   );

   // ---------------- k2 squared ----------------
   k2sq_side_type                    m2_side_in;
   val_type [0:0]                    m2_a, m2_cap, m2_p;
   logic                             m2_v;
   logic [$bits(k2sq_side_type)-1:0] m2_side;
   k2sq_side_type                    m2_s;

   assign m2_side_in.k2 = dv_quo[0];
   assign m2_side_in.t  = dv_quo[1];
   assign m2_side_in.ds = div_side_type'(dv_side);
   assign m2_a[0]       = dv_quo[0];
   assign m2_cap[0]     = VAL_MAX;
   assign m2_s          = k2sq_side_type'(m2_side);

   cci_mul #(
      .LANES     (1),
      .FRAC_BITS (FRAC_BITS),
      .SIDE_W    ($bits(k2sq_side_type))
   ) u_mul_k2 (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (dv_v),
      .a         (m2_a),
      .b         (m2_a),
      .cap       (m2_cap),
      .in_side   (m2_side_in),
      .out_valid (m2_v),
      .prod      (m2_p),
      .out_side  (m2_side)
   );

   // ---------------- stage E: radicand and status ----------------
   logic           e_v_ff;
   root_side_type  e_side_in, e_side_ff;
   val_type        e_rad_in, e_rad_ff;
   logic [VAL_W:0] tk;

   always_comb begin
      tk              = {1'b0, m2_s.t} - {1'b0, m2_p[0]};
      e_rad_in        = tk[VAL_W-1:0] - ONE_FIX;
      e_side_in.k2    = m2_s.k2;
      e_side_in.k2neg = m2_s.ds.k2neg;
      e_side_in.geo   = m2_s.ds.geo;
      if (m2_s.ds.conc) begin
         e_side_in.status = STATUS_CONCENTRIC;
      end else if (tk[VAL_W] || (tk[VAL_W-1:0] < ONE_FIX)) begin
         e_side_in.status = STATUS_APART;
      end else begin
         e_side_in.status = STATUS_OK;
      end
   end

   // ---------------- square root: one root bit per stage ----------------
   logic                sq_v_ff    [SQ_PAIRS];
   logic [SQ_W-1:0]     sq_val_ff  [SQ_PAIRS];
   logic [SQ_PAIRS-1:0] sq_root_ff [SQ_PAIRS];
   logic [SQ_RW-1:0]    sq_rem_ff  [SQ_PAIRS];
   root_side_type       sq_side_ff [SQ_PAIRS];

   for (genvar s = 0; s < SQ_PAIRS; s++) begin : g_root
      logic                v_prev;
      logic [SQ_W-1:0]     val_prev, val_in;
      logic [SQ_PAIRS-1:0] root_prev, root_in;
      logic [SQ_RW-1:0]    rem_prev, rem_in;
      root_side_type       side_prev;
      logic [SQ_TW-1:0]    cur, trial;
      logic                ge;

      if (s == 0) begin : g_first
         assign v_prev    = e_v_ff;
         assign val_prev  = SQ_W'(e_rad_ff) << FRAC_BITS;
         assign root_prev = '0;
         assign rem_prev  = '0;
         assign side_prev = e_side_ff;
      end else begin : g_next
         assign v_prev    = sq_v_ff[s-1];
         assign val_prev  = sq_val_ff[s-1];
         assign root_prev = sq_root_ff[s-1];
         assign rem_prev  = sq_rem_ff[s-1];
         assign side_prev = sq_side_ff[s-1];
      end

      assign cur     = (SQ_TW'(rem_prev) << 2) | SQ_TW'(val_prev[SQ_W-1 -: 2]);
      assign trial   = (SQ_TW'(root_prev) << 2) | SQ_TW'(1);
      assign ge      = cur >= trial;
      assign rem_in  = ge ? SQ_RW'(cur - trial) : SQ_RW'(cur);
      assign root_in = {root_prev[SQ_PAIRS-2:0], ge};
      assign val_in  = val_prev << 2;

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_v_ff[s] <= 1'b0;
         end else if (en) begin
            sq_v_ff[s] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            sq_val_ff[s]  <= val_in;
            sq_root_ff[s] <= root_in;
            sq_rem_ff[s]  <= rem_in;
            sq_side_ff[s] <= side_prev;
         end
      end
   end

   // ---------------- linear terms: k2*dx, k2*dy, k3*dy, k3*dx ----------------
   root_side_type                   sq_last;
   lin_side_type                    m3_side_in, m3_s;
   val_type [3:0]                   m3_a, m3_b, m3_cap, m3_p;
   logic                            m3_v;
   logic [$bits(lin_side_type)-1:0] m3_side;

   assign sq_last           = sq_side_ff[SQ_PAIRS-1];
   assign m3_side_in.status = sq_last.status;
   assign m3_side_in.k2neg  = sq_last.k2neg;
   assign m3_side_in.geo    = sq_last.geo;
   assign m3_a[0] = sq_last.k2;
   assign m3_a[1] = sq_last.k2;
   assign m3_a[2] = VAL_W'(sq_root_ff[SQ_PAIRS-1]);
   assign m3_a[3] = VAL_W'(sq_root_ff[SQ_PAIRS-1]);
   assign m3_b[0] = VAL_W'(sq_last.geo.dxmag);
   assign m3_b[1] = VAL_W'(sq_last.geo.dymag);
   assign m3_b[2] = VAL_W'(sq_last.geo.dymag);
   assign m3_b[3] = VAL_W'(sq_last.geo.dxmag);
   assign m3_cap  = {4{LIN_CAP}};
   assign m3_s    = lin_side_type'(m3_side);

   cci_mul #(
      .LANES     (4),
      .FRAC_BITS (FRAC_BITS),
      .SIDE_W    ($bits(lin_side_type))
   ) u_mul_lin (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sq_v_ff[SQ_PAIRS-1]),
      .a         (m3_a),
      .b         (m3_b),
      .cap       (m3_cap),
      .in_side   (m3_side_in),
      .out_valid (m3_v),
      .prod      (m3_p),
      .out_side  (m3_side)
   );

   // ---------------- stage F: signed terms ----------------
   logic     f_v_ff;
   term_type f_in, f_ff;

   always_comb begin
      f_in.status = m3_s.status;
      f_in.fx = {{(VAL_W-DIF_W){m3_s.geo.sumx[DIF_W-1]}}, m3_s.geo.sumx}
              + apply_sign(m3_p[0], m3_s.k2neg ^ m3_s.geo.dxneg);
      f_in.fy = {{(VAL_W-DIF_W){m3_s.geo.sumy[DIF_W-1]}}, m3_s.geo.sumy}
              + apply_sign(m3_p[1], m3_s.k2neg ^ m3_s.geo.dyneg);
      f_in.gx = apply_sign(m3_p[2], m3_s.geo.dyneg);
      f_in.gy = apply_sign(m3_p[3], !m3_s.geo.dxneg);
   end

   // ---------------- stage G: point sums ----------------
   logic    g_v_ff;
   sum_type g_in, g_ff;

   always_comb begin
      g_in.status = f_ff.status;
      g_in.sax    = f_ff.fx + f_ff.gx;
      g_in.say    = f_ff.fy + f_ff.gy;
      g_in.sbx    = f_ff.fx - f_ff.gx;
      g_in.sby    = f_ff.fy - f_ff.gy;
   end

   // ---------------- stage H: halve, saturate, zero on bad status ----------------
   logic    h_v_ff;
   out_type h_in, h_ff;

   always_comb begin
      h_in.status = g_ff.status;
      if (g_ff.status == STATUS_OK) begin
         h_in.ax = half_sat(g_ff.sax);
         h_in.ay = half_sat(g_ff.say);
         h_in.bx = half_sat(g_ff.sbx);
         h_in.by = half_sat(g_ff.sby);
      end else begin
         h_in.ax = '0;
         h_in.ay = '0;
         h_in.bx = '0;
         h_in.by = '0;
      end
   end

   // Advance all valid bits together; hold while the output queue is full.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
         c_v_ff <= 1'b0;
         d_v_ff <= 1'b0;
         e_v_ff <= 1'b0;
         f_v_ff <= 1'b0;
         g_v_ff <= 1'b0;
         h_v_ff <= 1'b0;
      end else if (en) begin
         a_v_ff <= req_tvalid;
         b_v_ff <= a_v_ff;
         c_v_ff <= m1_v;
         d_v_ff <= c_v_ff;
         e_v_ff <= m2_v;
         f_v_ff <= m3_v;
         g_v_ff <= f_v_ff;
         h_v_ff <= g_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff       <= a_in;
         b_ff       <= b_in;
         c_ff       <= c_in;
         d_side_ff  <= d_side_in;
         d_k2num_ff <= d_k2num_in;
         d_tnum_ff  <= d_tnum_in;
         d_d2_ff    <= c_ff.d2;
         e_side_ff  <= e_side_in;
         e_rad_ff   <= e_rad_in;
         f_ff       <= f_in;
         g_ff       <= g_in;
         h_ff       <= h_in;
      end
   end

   // ---------------- output queue: output register plus skid entry ----------------
   out_type out_ff, skid_ff;
   logic    push, pop;

   assign push = en && h_v_ff;
   assign pop  = out_v_ff && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (skid_v_ff) begin
         if (pop) begin
            skid_v_ff <= 1'b0;
         end
      end else if (push) begin
         if (out_v_ff && !pop) begin
            skid_v_ff <= 1'b1;
         end else begin
            out_v_ff <= 1'b1;
         end
      end else if (pop) begin
         out_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_v_ff) begin
         if (pop) begin
            out_ff <= skid_ff;
         end
      end else if (push) begin
         if (out_v_ff && !pop) begin
            skid_ff <= h_ff;
         end else begin
            out_ff <= h_ff;
         end
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tuser  = out_ff.status;
   assign rsp_tdata  = RSP_DATA_W'({out_ff.by, out_ff.bx, out_ff.ay, out_ff.ax});

`include "circle_circle_intersection_assert.svh"

   `CCI_ASSERT_SAME(a_skid_needs_out, clock, reset, skid_v_ff, out_v_ff, "skid entry held without an output entry")
   `CCI_ASSERT_SAME(a_bad_status_zero, clock, reset, rsp_tvalid && (rsp_tuser != STATUS_OK), rsp_tdata == '0, "points not zero on a failed query")
   `CCI_ASSERT_NEXT(a_stall_fills_skid, clock, reset, out_v_ff && !rsp_tready && en && h_v_ff, skid_v_ff, "stalled result not parked in skid entry")

endmodule
